FILE: src/sha1_message_hasher_assert.svh
// Assertion macros shared by the SHA-1 hasher RTL.
// Uses the clk and rst names of the including module; no other dependencies.
`ifndef SHA1_MESSAGE_HASHER_ASSERT_SVH
`define SHA1_MESSAGE_HASHER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SHA1MH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SHA1MH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sha1mh_pkg.sv
// Shared types, constants and command/status structs for the SHA-1 hasher.
// No dependencies; imported by every module of the block.
package sha1mh_pkg;

  localparam int unsigned NUM_HASH  = 5;
  localparam int unsigned NUM_SCHED = 16;

  // Input and output transactions
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       last_item;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  localparam logic [31:0] H_INIT [NUM_HASH] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_CHOOSE   = 32'h5A827999;
  localparam logic [31:0] K_PARITY1  = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
  localparam logic [31:0] K_PARITY2  = 32'hCA62C1D6;

  localparam logic [7:0]  PAD_BYTE      = 8'h80;
  localparam logic [5:0]  LEN_FILL      = 6'd56;
  localparam logic [5:0]  LAST_FILL     = 6'd63;
  localparam logic [6:0]  LAST_ROUND    = 7'd79;
  localparam logic [6:0]  END_CHOOSE    = 7'd20;
  localparam logic [6:0]  END_PARITY1   = 7'd40;
  localparam logic [6:0]  END_MAJORITY  = 7'd60;
  localparam logic [2:0]  LAST_LEN_BYTE = 3'd7;
  localparam logic [2:0]  DIGEST_WORDS  = 3'd5;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_ONE,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_ROUND,
    ST_ADD,
    ST_DIGEST
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SRC_MSG,
    SRC_PAD_ONE,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef enum logic [1:0] {
    FN_CHOOSE,
    FN_PARITY1,
    FN_MAJORITY,
    FN_PARITY2
  } round_fn_t;

  // Controller to datapath
  typedef struct packed {
    logic      put;         // absorb one byte into the block
    byte_src_t src;         // where that byte comes from
    logic [2:0] len_idx;    // length byte, most significant first
    logic      count_bits;  // advance the message bit count
    logic      load_round;  // load working registers from the chain
    logic      round_en;    // run one compression round
    round_fn_t fn;          // round function group
    logic      add_chain;   // fold working registers into the chain
    logic      finish;      // move digest to output, restart the hash
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [5:0] fill;
    logic       dig_busy;
  } status_t;

endpackage

FILE: src/sha1mh_ctrl.sv
// Sequencer for the SHA-1 hasher: absorb, pad, round count and digest hand-off.
// Depends on sha1mh_pkg; drives the datapath through cmd_t only.
module sha1mh_ctrl import sha1mh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      msg_valid,
  input  msg_item_t msg,
  output logic      msg_stall,
  input  status_t   status,
  output cmd_t      cmd
);

  ctrl_state_t state, state_next;
  ctrl_state_t ret_state, ret_state_next;
  logic [6:0]  round_cnt, round_cnt_next;
  logic [2:0]  len_idx, len_idx_next;
  logic        block_done;

  assign block_done = (status.fill == LAST_FILL);

  // Next state, return point and counters
  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    round_cnt_next = round_cnt;
    len_idx_next   = len_idx;
    unique case (state)
      ST_IDLE: begin
        if (msg_valid) begin
          if (msg.byte_valid && block_done) begin
            state_next     = ST_ROUND;
            ret_state_next = msg.last_item ? ST_PAD_ONE : ST_IDLE;
          end else if (msg.last_item) begin
            state_next = ST_PAD_ONE;
          end
        end
      end
      ST_PAD_ONE: begin
        if (block_done) begin
          state_next     = ST_ROUND;
          ret_state_next = ST_PAD_ZERO;
        end else begin
          state_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (status.fill == LEN_FILL) begin
          state_next   = ST_PAD_LEN;
          len_idx_next = '0;
        end else if (block_done) begin
          state_next     = ST_ROUND;
          ret_state_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_LEN: begin
        len_idx_next = len_idx + 3'd1;
        if (block_done) begin
          state_next     = ST_ROUND;
          ret_state_next = ST_DIGEST;
        end
      end
      ST_ROUND: begin
        if (round_cnt == LAST_ROUND) begin
          round_cnt_next = '0;
          state_next     = ST_ADD;
        end else begin
          round_cnt_next = round_cnt + 7'd1;
        end
      end
      ST_ADD: begin
        state_next = ret_state;
      end
      ST_DIGEST: begin
        if (!status.dig_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd            = '0;
    cmd.src        = SRC_MSG;
    cmd.len_idx    = len_idx;
    msg_stall      = (state != ST_IDLE);
    if (round_cnt < END_CHOOSE) begin
      cmd.fn = FN_CHOOSE;
    end else if (round_cnt < END_PARITY1) begin
      cmd.fn = FN_PARITY1;
    end else if (round_cnt < END_MAJORITY) begin
      cmd.fn = FN_MAJORITY;
    end else begin
      cmd.fn = FN_PARITY2;
    end
    unique case (state)
      ST_IDLE: begin
        cmd.put        = msg_valid && msg.byte_valid;
        cmd.count_bits = msg_valid && msg.byte_valid;
        cmd.load_round = msg_valid && msg.byte_valid && block_done;
      end
      ST_PAD_ONE: begin
        cmd.put        = 1'b1;
        cmd.src        = SRC_PAD_ONE;
        cmd.load_round = block_done;
      end
      ST_PAD_ZERO: begin
        cmd.put        = (status.fill != LEN_FILL);
        cmd.src        = SRC_ZERO;
        cmd.load_round = block_done;
      end
      ST_PAD_LEN: begin
        cmd.put        = 1'b1;
        cmd.src        = SRC_LEN;
        cmd.load_round = block_done;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
      end
      ST_ADD: begin
        cmd.add_chain = 1'b1;
      end
      ST_DIGEST: begin
        cmd.finish = !status.dig_busy;
      end
      default: begin
        cmd.put = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
      round_cnt <= '0;
      len_idx   <= '0;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
      round_cnt <= round_cnt_next;
      len_idx   <= len_idx_next;
    end
  end

endmodule

FILE: src/sha1mh_datapath.sv
// SHA-1 datapath: byte packing, rolling schedule, round unit, chain and digest buffer.
// Depends on sha1mh_pkg; controlled by sha1mh_ctrl through cmd_t.
module sha1mh_datapath import sha1mh_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  input  logic [7:0]   msg_byte,
  output status_t      status,
  output logic         dig_valid,
  input  logic         dig_stall,
  output digest_item_t dig
);

  logic [31:0] chain [NUM_HASH];
  logic [31:0] work  [NUM_HASH];
  logic [31:0] sched [NUM_SCHED];
  logic [31:0] dig_buf [NUM_HASH];
  logic [63:0] bits;
  logic [5:0]  fill;
  logic [23:0] acc;
  logic [2:0]  dig_cnt;

  logic [7:0]  put_byte;
  logic [5:0]  len_shift;
  logic [31:0] w_mix, w_new, f_val, k_val, t_val;

  // Select the byte to absorb
  assign len_shift = {LAST_LEN_BYTE - cmd.len_idx, 3'b000};
  always_comb begin
    unique case (cmd.src)
      SRC_MSG:     put_byte = msg_byte;
      SRC_PAD_ONE: put_byte = PAD_BYTE;
      SRC_ZERO:    put_byte = 8'h00;
      SRC_LEN:     put_byte = bits[len_shift +: 8];
      default:     put_byte = 8'h00;
    endcase
  end

  // Schedule expansion from the fixed taps of the shift line
  assign w_mix = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  // Round function and constant
  always_comb begin
    unique case (cmd.fn)
      FN_CHOOSE: begin
        f_val = (work[1] & work[2]) | (~work[1] & work[3]);
        k_val = K_CHOOSE;
      end
      FN_PARITY1: begin
        f_val = work[1] ^ work[2] ^ work[3];
        k_val = K_PARITY1;
      end
      FN_MAJORITY: begin
        f_val = (work[1] & work[2]) | (work[1] & work[3]) | (work[2] & work[3]);
        k_val = K_MAJORITY;
      end
      FN_PARITY2: begin
        f_val = work[1] ^ work[2] ^ work[3];
        k_val = K_PARITY2;
      end
      default: begin
        f_val = '0;
        k_val = '0;
      end
    endcase
  end

  assign t_val = {work[0][26:0], work[0][31:27]} + f_val + work[4] + k_val + sched[0];

  // Control-side counters and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      bits <= '0;
      for (int i = 0; i < NUM_HASH; i++) begin
        chain[i] <= H_INIT[i];
      end
    end else begin
      if (cmd.put) begin
        fill <= fill + 6'd1;
      end
      if (cmd.count_bits) begin
        bits <= bits + BITS_PER_BYTE;
      end
      if (cmd.add_chain) begin
        for (int i = 0; i < NUM_HASH; i++) begin
          chain[i] <= chain[i] + work[i];
        end
      end
      if (cmd.finish) begin
        fill <= '0;
        bits <= '0;
        for (int i = 0; i < NUM_HASH; i++) begin
          chain[i] <= H_INIT[i];
        end
      end
    end
  end

  // Byte packing and schedule shift line
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      acc <= {acc[15:0], put_byte};
    end
    if (cmd.put && (fill[1:0] == 2'b11)) begin
      for (int i = 0; i < NUM_SCHED - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[NUM_SCHED - 1] <= {acc, put_byte};
    end else if (cmd.round_en) begin
      for (int i = 0; i < NUM_SCHED - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[NUM_SCHED - 1] <= w_new;
    end
  end

  // Working registers a..e
  always_ff @(posedge clk) begin
    if (cmd.load_round) begin
      for (int i = 0; i < NUM_HASH; i++) begin
        work[i] <= chain[i];
      end
    end else if (cmd.round_en) begin
      work[0] <= t_val;
      work[1] <= work[0];
      work[2] <= {work[1][1:0], work[1][31:2]};
      work[3] <= work[2];
      work[4] <= work[3];
    end
  end

  // Digest buffer: load on finish, drain one word per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      dig_cnt <= '0;
    end else if (cmd.finish) begin
      dig_cnt <= DIGEST_WORDS;
    end else if (dig_valid && !dig_stall) begin
      dig_cnt <= dig_cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      for (int i = 0; i < NUM_HASH; i++) begin
        dig_buf[i] <= chain[i];
      end
    end else if (dig_valid && !dig_stall) begin
      for (int i = 0; i < NUM_HASH - 1; i++) begin
        dig_buf[i] <= dig_buf[i + 1];
      end
    end
  end

  assign dig_valid       = (dig_cnt != 3'd0);
  assign dig.digest_word = dig_buf[0];
  assign dig.word_index  = DIGEST_WORDS - dig_cnt;
  assign dig.last_word   = (dig_cnt == 3'd1);

  assign status.fill     = fill;
  assign status.dig_busy = dig_valid;

endmodule

FILE: src/sha1_message_hasher.sv
// Top level of the SHA-1 message hasher: controller plus datapath.
// Depends on sha1mh_pkg, sha1mh_ctrl, sha1mh_datapath and the assertion macro header.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+--------------------------------------
//   msg     | msg_valid | msg_stall | msg_item_t: msg_byte, byte_valid, last_item
//   dig     | dig_valid | dig_stall | digest_item_t: digest_word, word_index, last_word
//
// Message bytes are taken while the input is not stalled; a full 64-byte block adds 80
// rounds and a chain add. A last item adds the pad bytes (9 to 64, or up to 72 with
// an extra block), a length boundary step, the compressions and the digest hand-off.
// Digest words drain one per transaction while new bytes are taken; the next
// digest, and with it the input, waits until the buffer is empty.
// rst is synchronous; after it the hash restarts from the initial values.
`include "sha1_message_hasher_assert.svh"

module sha1_message_hasher import sha1mh_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         msg_valid,
  output logic         msg_stall,
  input  msg_item_t    msg,
  output logic         dig_valid,
  input  logic         dig_stall,
  output digest_item_t dig
);

  cmd_t    cmd;
  status_t status;
  logic    plain_byte;
  logic    put_in_round;
  logic    last_mark_ok;

  sha1mh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg       (msg),
    .msg_stall (msg_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sha1mh_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .msg_byte  (msg.msg_byte),
    .status    (status),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

  // Check terms
  assign plain_byte   = msg_valid && !msg_stall && msg.byte_valid && !msg.last_item
                        && (status.fill != LAST_FILL);
  assign put_in_round = cmd.round_en || cmd.add_chain;
  assign last_mark_ok = (dig.last_word == (dig.word_index == DIGEST_WORDS - 3'd1));

  // A plain byte that does not close a block leaves the input open
  `SHA1MH_ASSERT_NEXT(a_byte_keeps_ready, plain_byte, !msg_stall, "stall after a plain byte")
  // Packing and round shifting never share a cycle
  `SHA1MH_ASSERT_SAME(a_put_excl_round, cmd.put, !put_in_round, "byte put during compression")
  // A new digest only enters an empty output buffer
  `SHA1MH_ASSERT_SAME(a_finish_empty_buf, cmd.finish, !dig_valid, "digest over pending words")
  // The final digest word carries the last mark
  `SHA1MH_ASSERT_SAME(a_last_word_index, dig_valid, last_mark_ok, "last mark on wrong word")

endmodule
